/* hw/rtl/serpent_block_cipher_defines.svh */
// Assertion macros for the Serpent block cipher RTL
`ifndef SERPENT_BLOCK_CIPHER_DEFINES_SVH
`define SERPENT_BLOCK_CIPHER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define SBC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SBC_ASSERT(label, clk, rst, prop)
`define SBC_ASSERT_RST(label, clk, prop)
`endif
`endif

/* hw/rtl/sbc_pkg.sv */
// Shared types, constants and round functions for the Serpent block cipher
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;
  localparam int RoundCountDefault = 32;
  localparam int KeyWords = 132;
  localparam int KeyIdxW = 8;
  localparam int KeyAddrW = 8;

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeEnc  = 2'd1;
  localparam logic [1:0] ModeDec  = 2'd2;

  typedef struct packed {
    logic         dec;
    logic [127:0] blk;
  } job_t;

  function automatic logic [3:0] sb_lookup(input logic [2:0] s, input logic [3:0] v,
                                           input logic inv);
    logic [3:0] tf [8][16];
    logic [3:0] res;
    tf = '{
      '{4'd3,4'd8,4'd15,4'd1,4'd10,4'd6,4'd5,4'd11,4'd14,4'd13,4'd4,4'd2,4'd7,4'd0,4'd9,4'd12},
      '{4'd15,4'd12,4'd2,4'd7,4'd9,4'd0,4'd5,4'd10,4'd1,4'd11,4'd14,4'd8,4'd6,4'd13,4'd3,4'd4},
      '{4'd8,4'd6,4'd7,4'd9,4'd3,4'd12,4'd10,4'd15,4'd13,4'd1,4'd14,4'd4,4'd0,4'd11,4'd5,4'd2},
      '{4'd0,4'd15,4'd11,4'd8,4'd12,4'd9,4'd6,4'd3,4'd13,4'd1,4'd2,4'd4,4'd10,4'd7,4'd5,4'd14},
      '{4'd1,4'd15,4'd8,4'd3,4'd12,4'd0,4'd11,4'd6,4'd2,4'd5,4'd4,4'd10,4'd9,4'd14,4'd7,4'd13},
      '{4'd15,4'd5,4'd2,4'd11,4'd4,4'd10,4'd9,4'd12,4'd0,4'd3,4'd14,4'd8,4'd13,4'd6,4'd7,4'd1},
      '{4'd7,4'd2,4'd12,4'd5,4'd8,4'd4,4'd6,4'd11,4'd14,4'd9,4'd1,4'd15,4'd13,4'd3,4'd10,4'd0},
      '{4'd1,4'd13,4'd15,4'd0,4'd14,4'd8,4'd2,4'd11,4'd7,4'd4,4'd12,4'd10,4'd9,4'd3,4'd5,4'd6}};
    res = '0;
    if (!inv) begin
      res = tf[s][v];
    end else begin
      for (int k = 0; k < 16; k++) begin
        if (tf[s][k] == v) res = 4'(k);
      end
    end
    return res;
  endfunction

  function automatic logic [127:0] apply_box(input logic [127:0] b, input logic [2:0] s,
                                             input logic inv);
    logic [127:0] o;
    logic [3:0] n;
    for (int i = 0; i < 32; i++) begin
      n = {b[96+i], b[64+i], b[32+i], b[i]};
      n = sb_lookup(s, n, inv);
      o[i] = n[0];
      o[32+i] = n[1];
      o[64+i] = n[2];
      o[96+i] = n[3];
    end
    return o;
  endfunction

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [127:0] lin_fwd(input logic [127:0] b);
    logic [31:0] w0, w1, w2, w3;
    {w3, w2, w1, w0} = b;
    w0 = rl(w0, 13);
    w2 = rl(w2, 3);
    w1 = w1 ^ w0 ^ w2;
    w3 = w3 ^ w2 ^ (w0 << 3);
    w1 = rl(w1, 1);
    w3 = rl(w3, 7);
    w0 = w0 ^ w1 ^ w3;
    w2 = w2 ^ w3 ^ (w1 << 7);
    w0 = rl(w0, 5);
    w2 = rl(w2, 22);
    return {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] lin_inv(input logic [127:0] b);
    logic [31:0] w0, w1, w2, w3;
    {w3, w2, w1, w0} = b;
    w2 = rr(w2, 22);
    w0 = rr(w0, 5);
    w2 = w2 ^ w3 ^ (w1 << 7);
    w0 = w0 ^ w1 ^ w3;
    w3 = rr(w3, 7);
    w1 = rr(w1, 1);
    w3 = w3 ^ w2 ^ (w0 << 3);
    w1 = w1 ^ w0 ^ w2;
    w2 = rr(w2, 3);
    w0 = rr(w0, 13);
    return {w3, w2, w1, w0};
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/serpent_block_cipher.sv */
// Serpent block cipher top level
// Use: one input channel (valid/stall) takes items with a mode.
//   Mode 0 writes round-key word key_index (0..131) with key_word; no result.
//   Mode 1 encrypts, mode 2 decrypts {block_high, block_low}; one result each.
//   Mode 3 is dropped.
// Key words 4r..4r+3 form subkey r; load all of them before ciphering.
// A front end takes items into a two-entry job queue; key loads go straight
// to the key memory. The back end runs one round per cycle on a shared
// round unit that reads one subkey per cycle from registered key banks.
// The back end takes a new block only from idle, once the previous result has
// been taken; the front end can queue blocks meanwhile.
// Output: result_valid holds with a stable payload while result_stall is high.
// Reset clears queue and control; key memory contents are kept and undefined
// until written.
`timescale 1ns / 1ps
`default_nettype none
module serpent_block_cipher #(
  parameter int ROUND_COUNT = sbc_pkg::RoundCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  key_index,
  input  wire logic [31:0] key_word,
  input  wire logic [63:0] block_low,
  input  wire logic [63:0] block_high,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [63:0]      result_low,
  output logic [63:0]      result_high
);
  logic                         key_we;
  logic [sbc_pkg::KeyAddrW-1:0] key_waddr;
  logic [31:0]                  key_wdata;
  logic                         job_valid, job_take;
  sbc_pkg::job_t                job;
  logic [127:0]                 blk;

  sbc_front u_front (
    .clk, .rst, .valid, .stall, .mode, .key_index, .key_word, .block_low, .block_high,
    .key_we, .key_waddr, .key_wdata, .job_valid, .job, .job_take
  );

  sbc_back #(.RoundCount(ROUND_COUNT)) u_back (
    .clk, .rst, .key_we, .key_waddr, .key_wdata, .job_valid, .job, .job_take,
    .out_valid(result_valid), .out_stall(result_stall), .out_blk(blk)
  );

  assign result_low = blk[63:0];
  assign result_high = blk[127:64];
endmodule
`default_nettype wire

/* hw/rtl/sbc_front.sv */
// Front end: accepts items, writes round keys, queues cipher jobs
`timescale 1ns / 1ps
`default_nettype none
`include "serpent_block_cipher_defines.svh"
module sbc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        valid,
  output logic                             stall,
  input  wire logic [1:0]                  mode,
  input  wire logic [sbc_pkg::KeyIdxW-1:0] key_index,
  input  wire logic [31:0]                 key_word,
  input  wire logic [63:0]                 block_low,
  input  wire logic [63:0]                 block_high,
  output logic                             key_we,
  output logic [sbc_pkg::KeyAddrW-1:0]     key_waddr,
  output logic [31:0]                      key_wdata,
  output logic                             job_valid,
  output sbc_pkg::job_t                    job,
  input  wire logic                        job_take
);
  // two-entry queue
  sbc_pkg::job_t q [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push, acc;

  assign stall = (cnt == 2'd2);
  assign acc = valid && !stall;
  assign push = acc && (mode == sbc_pkg::ModeEnc || mode == sbc_pkg::ModeDec);
  assign key_we = acc && mode == sbc_pkg::ModeLoad && key_index < 8'(sbc_pkg::KeyWords);
  assign key_waddr = key_index;
  assign key_wdata = key_word;
  assign job_valid = (cnt != 2'd0);
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (job_take) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(job_take);
    end
    if (push) begin
      q[wp] <= '{dec: (mode == sbc_pkg::ModeDec), blk: {block_high, block_low}};
    end
  end

  `SBC_ASSERT(a_no_over, clk, rst, cnt == 2'd2 |-> !push)
  `SBC_ASSERT(a_no_under, clk, rst, job_take |-> cnt != 2'd0)
  `SBC_ASSERT(a_cnt, clk, rst, cnt != 2'd3)
endmodule
`default_nettype wire

/* hw/rtl/sbc_back.sv */
// Back end: round-key memory and iterative round unit, one round per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "serpent_block_cipher_defines.svh"
module sbc_back #(
  parameter int RoundCount = sbc_pkg::RoundCountDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        key_we,
  input  wire logic [sbc_pkg::KeyAddrW-1:0] key_waddr,
  input  wire logic [31:0]                 key_wdata,
  input  wire logic                        job_valid,
  input  sbc_pkg::job_t                    job,
  output logic                             job_take,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [127:0]                     out_blk
);
  localparam int RW = $clog2(RoundCount + 1);
  localparam int SW = $clog2(RoundCount + 2);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  // four banks, one word per subkey each
  logic [31:0] bank0 [RoundCount+1];
  logic [31:0] bank1 [RoundCount+1];
  logic [31:0] bank2 [RoundCount+1];
  logic [31:0] bank3 [RoundCount+1];

  state_t        state;
  logic          dec;
  logic [SW-1:0] step;
  logic [RW-1:0] rd_k;
  logic [127:0]  sk, st;
  logic [127:0]  x, y;
  logic [RW-1:0] r;
  logic [RW-1:0] rd_next;
  logic          fire;

  always_ff @(posedge clk) begin
    if (key_we && key_waddr < 8'(4 * (RoundCount + 1))) begin
      case (key_waddr[1:0])
        2'd0: bank0[RW'(key_waddr >> 2)] <= key_wdata;
        2'd1: bank1[RW'(key_waddr >> 2)] <= key_wdata;
        2'd2: bank2[RW'(key_waddr >> 2)] <= key_wdata;
        default: bank3[RW'(key_waddr >> 2)] <= key_wdata;
      endcase
    end
    sk <= {bank3[rd_next], bank2[rd_next], bank1[rd_next], bank0[rd_next]};
  end

  assign fire = (state == S_IDLE) && job_valid;
  assign job_take = fire;

  // first subkey is fetched as the job is taken; steps 1..RoundCount run rounds
  always_comb begin
    rd_next = rd_k;
    if (fire) begin
      rd_next = job.dec ? RW'(RoundCount) : '0;
    end else if (state == S_RUN) begin
      if (!dec) rd_next = (rd_k == RW'(RoundCount)) ? rd_k : rd_k + 1'b1;
      else rd_next = (rd_k == '0) ? rd_k : rd_k - 1'b1;
    end
  end

  always_comb begin
    r = RW'(step - 1'b1);
    x = st ^ sk;
    y = x;
    if (!dec) begin
      if (r == RW'(RoundCount)) begin
        y = x;
      end else begin
        y = sbc_pkg::apply_box(x, r[2:0], 1'b0);
        if (r != RW'(RoundCount - 1)) y = sbc_pkg::lin_fwd(y);
      end
    end else begin
      // round index counted down: RoundCount-1 .. 0, then final key
      if (r == RW'(RoundCount)) begin
        y = x;
      end else begin
        if (r != '0) y = sbc_pkg::lin_inv(x);
        y = sbc_pkg::apply_box(y, 3'(RoundCount - 1 - int'(r)), 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      step <= '0;
      rd_k <= '0;
    end else begin
      rd_k <= rd_next;
      case (state)
        S_IDLE: begin
          if (fire) begin
            state <= S_RUN;
            dec <= job.dec;
            st <= job.blk;
            step <= SW'(1);
          end
        end
        S_RUN: begin
          st <= y;
          if (step == SW'(RoundCount + 1)) begin
            state <= S_DONE;
            out_valid <= 1'b1;
            out_blk <= y;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SBC_ASSERT(a_done_valid, clk, rst, (state == S_DONE) == out_valid)
  `SBC_ASSERT(a_take_idle, clk, rst, job_take |-> state == S_IDLE)
  `SBC_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_blk))
endmodule
`default_nettype wire
